// ===== design/assert_macros.svh =====
// assertion macros used by deformation_field_upsample_2x
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("same-cycle implication failed");

`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, b)

`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// ===== design/dfu_pkg.sv =====
package dfu_pkg;

	localparam int IDX_W          = 6;
	localparam int SIZE_W         = 6;
	localparam int CFG_IDX_W      = 2;
	localparam int EXT_W          = 9;
	localparam int DEF_MAX_DIM    = 32;
	localparam int DEF_VALUE_BITS = 24;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_RUN,
		SEQ_DRAIN
	} seq_state_t;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic [1:0] shift;
	} rd_tag_t;

	function automatic logic [EXT_W-1:0] eff_size(input logic [SIZE_W-1:0] s, input int maxd);
		logic [EXT_W-1:0] r;
		r = EXT_W'(s);
		if (s == '0) begin
			r = EXT_W'(1);
		end else if (int'(s) > maxd) begin
			r = EXT_W'(maxd);
		end
		return r;
	endfunction

endpackage

// ===== design/deformation_field_upsample_2x.sv =====
// Trilinear 2x upsampler for a three-component 3D field held in one
// simple dual-port synchronous memory. A write request (mode 0) gives no
// result. A query (mode 1) out of range strobes done with index_error in the
// next cycle. A query in range reads 2^k neighbors, k being the number of odd
// indexes, one per cycle from the memory read port: busy is high while the
// reads run and in a drain state after them, and done strobes for one cycle
// right after busy falls. A new request is accepted only while busy is low.
// The receiver cannot stall: a result must be taken in the cycle done is
// high. The memory has no reset and no clearing pass; a query may only touch
// entries already written.
`include "assert_macros.svh"

module deformation_field_upsample_2x #(
	parameter int MAX_DIM    = dfu_pkg::DEF_MAX_DIM,
	parameter int VALUE_BITS = dfu_pkg::DEF_VALUE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dfu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dfu_pkg::SIZE_W-1:0]    cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [dfu_pkg::IDX_W-1:0]     index_x,
	input  logic [dfu_pkg::IDX_W-1:0]     index_y,
	input  logic [dfu_pkg::IDX_W-1:0]     index_z,
	input  logic signed [VALUE_BITS-1:0]  value_x,
	input  logic signed [VALUE_BITS-1:0]  value_y,
	input  logic signed [VALUE_BITS-1:0]  value_z,
	output logic signed [VALUE_BITS+2:0]  out_x,
	output logic signed [VALUE_BITS+2:0]  out_y,
	output logic signed [VALUE_BITS+2:0]  out_z,
	output logic                          index_error,
	output logic                          done
);

	localparam int CW = $clog2(MAX_DIM);
	localparam int AW = 3 * CW;
	localparam int DW = 3 * VALUE_BITS;
	localparam int EW = dfu_pkg::EXT_W;

	logic [dfu_pkg::SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [EW-1:0] n_x, n_y, n_z;
	logic [EW-1:0] ix, iy, iz;
	logic [EW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
	logic          accept, wr_ok, q_err, go, err_req, wr_en;
	logic          rd_en;
	logic [AW-1:0] raddr, waddr;
	logic [DW-1:0] rd_data;
	dfu_pkg::rd_tag_t tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= dfu_pkg::SIZE_RESET;
			size_y_q <= dfu_pkg::SIZE_RESET;
			size_z_q <= dfu_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dfu_pkg::REG_SIZE_X: size_x_q <= cfg_data;
				dfu_pkg::REG_SIZE_Y: size_y_q <= cfg_data;
				dfu_pkg::REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_x = dfu_pkg::eff_size(size_x_q, MAX_DIM);
	assign n_y = dfu_pkg::eff_size(size_y_q, MAX_DIM);
	assign n_z = dfu_pkg::eff_size(size_z_q, MAX_DIM);

	assign ix = EW'(index_x);
	assign iy = EW'(index_y);
	assign iz = EW'(index_z);

	assign accept  = start && !busy;
	assign wr_ok   = (ix < n_x) && (iy < n_y) && (iz < n_z);
	assign q_err   = ({1'b0, ix} >= {n_x, 1'b0}) || ({1'b0, iy} >= {n_y, 1'b0}) ||
			({1'b0, iz} >= {n_z, 1'b0});
	assign wr_en   = accept && !mode && wr_ok;
	assign go      = accept && mode && !q_err;
	assign err_req = accept && mode && q_err;

	// lower neighbor at half the index, upper one clamped to the last voxel
	assign lo_x = ix >> 1;
	assign lo_y = iy >> 1;
	assign lo_z = iz >> 1;
	assign hi_x = (ix[0] && (lo_x + EW'(1) < n_x)) ? lo_x + EW'(1) : lo_x;
	assign hi_y = (iy[0] && (lo_y + EW'(1) < n_y)) ? lo_y + EW'(1) : lo_y;
	assign hi_z = (iz[0] && (lo_z + EW'(1) < n_z)) ? lo_z + EW'(1) : lo_z;

	assign waddr = {ix[CW-1:0], iy[CW-1:0], iz[CW-1:0]};

	dfu_mem #(
		.AW (AW),
		.DW (DW)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata ({value_x, value_y, value_z}),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rd_data)
	);

	dfu_seq #(
		.CW (CW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.lo_x     (lo_x[CW-1:0]),
		.lo_y     (lo_y[CW-1:0]),
		.lo_z     (lo_z[CW-1:0]),
		.hi_x     (hi_x[CW-1:0]),
		.hi_y     (hi_y[CW-1:0]),
		.hi_z     (hi_z[CW-1:0]),
		.odd_mask ({ix[0], iy[0], iz[0]}),
		.busy     (busy),
		.rd_en    (rd_en),
		.raddr    (raddr),
		.tag      (tag)
	);

	dfu_acc #(
		.VB (VALUE_BITS)
	) u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.tag         (tag),
		.rd_data     (rd_data),
		.err_req     (err_req),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.index_error (index_error),
		.done        (done)
	);

	`ASSERT_NEXT(a_query_sets_busy, clk, arst_n, go, busy)
	`ASSERT_IMPLIES(a_read_only_busy, clk, arst_n, rd_en, busy && !wr_en)
	`ASSERT_IMPLIES(a_done_when_idle, clk, arst_n, done, !busy)

endmodule

// ===== design/dfu_mem.sv =====
module dfu_mem #(
	parameter int AW = 15,
	parameter int DW = 72
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/dfu_seq.sv =====
module dfu_seq #(
	parameter int CW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [CW-1:0]       lo_x,
	input  logic [CW-1:0]       lo_y,
	input  logic [CW-1:0]       lo_z,
	input  logic [CW-1:0]       hi_x,
	input  logic [CW-1:0]       hi_y,
	input  logic [CW-1:0]       hi_z,
	input  logic [2:0]          odd_mask,
	output logic                busy,
	output logic                rd_en,
	output logic [3*CW-1:0]     raddr,
	output dfu_pkg::rd_tag_t    tag
);

	dfu_pkg::seq_state_t state_q, state_d;

	logic [CW-1:0] lo_x_q, lo_y_q, lo_z_q, hi_x_q, hi_y_q, hi_z_q;
	logic [2:0]    mask_q;
	logic [2:0]    cnt_q;
	logic [2:0]    cnt_next;
	logic [1:0]    shift_q;

	// walk the subsets of the odd-axis mask
	assign cnt_next = ((cnt_q | ~mask_q) + 3'd1) & mask_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dfu_pkg::SEQ_IDLE: begin
				if (go) begin
					state_d = dfu_pkg::SEQ_RUN;
				end
			end
			dfu_pkg::SEQ_RUN: begin
				if (cnt_next == '0) begin
					state_d = dfu_pkg::SEQ_DRAIN;
				end
			end
			dfu_pkg::SEQ_DRAIN: begin
				state_d = dfu_pkg::SEQ_IDLE;
			end
			default: begin
				state_d = dfu_pkg::SEQ_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		rd_en     = 1'b0;
		tag.valid = 1'b0;
		tag.first = (cnt_q == '0);
		tag.last  = (cnt_next == '0);
		tag.shift = shift_q;
		case (state_q)
			dfu_pkg::SEQ_IDLE: begin
				busy = 1'b0;
			end
			dfu_pkg::SEQ_RUN: begin
				rd_en     = 1'b1;
				tag.valid = 1'b1;
			end
			dfu_pkg::SEQ_DRAIN: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign raddr = {cnt_q[2] ? hi_x_q : lo_x_q,
			cnt_q[1] ? hi_y_q : lo_y_q,
			cnt_q[0] ? hi_z_q : lo_z_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dfu_pkg::SEQ_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (go && state_q == dfu_pkg::SEQ_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == dfu_pkg::SEQ_RUN) begin
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && state_q == dfu_pkg::SEQ_IDLE) begin
			lo_x_q  <= lo_x;
			lo_y_q  <= lo_y;
			lo_z_q  <= lo_z;
			hi_x_q  <= hi_x;
			hi_y_q  <= hi_y;
			hi_z_q  <= hi_z;
			mask_q  <= odd_mask;
			shift_q <= 2'(3 - int'($countones(odd_mask)));
		end
	end

endmodule

// ===== design/dfu_acc.sv =====
module dfu_acc #(
	parameter int VB = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dfu_pkg::rd_tag_t    tag,
	input  logic [3*VB-1:0]     rd_data,
	input  logic                err_req,
	output logic signed [VB+2:0] out_x,
	output logic signed [VB+2:0] out_y,
	output logic signed [VB+2:0] out_z,
	output logic                index_error,
	output logic                done
);

	localparam int OW = VB + 3;

	dfu_pkg::rd_tag_t tag_s1;

	logic [OW-1:0] acc_x_q, acc_y_q, acc_z_q;
	logic [OW-1:0] ext_x, ext_y, ext_z;
	logic [OW-1:0] sum_x, sum_y, sum_z;
	logic [VB-1:0] d_x, d_y, d_z;

	assign d_x = rd_data[3*VB-1:2*VB];
	assign d_y = rd_data[2*VB-1:VB];
	assign d_z = rd_data[VB-1:0];

	assign ext_x = {{3{d_x[VB-1]}}, d_x};
	assign ext_y = {{3{d_y[VB-1]}}, d_y};
	assign ext_z = {{3{d_z[VB-1]}}, d_z};

	assign sum_x = (tag_s1.first ? '0 : acc_x_q) + ext_x;
	assign sum_y = (tag_s1.first ? '0 : acc_y_q) + ext_y;
	assign sum_z = (tag_s1.first ? '0 : acc_z_q) + ext_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			done   <= 1'b0;
		end else begin
			tag_s1 <= tag;
			done   <= err_req || (tag_s1.valid && tag_s1.last);
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s1.valid) begin
			acc_x_q <= sum_x;
			acc_y_q <= sum_y;
			acc_z_q <= sum_z;
		end
		if (err_req) begin
			out_x       <= '0;
			out_y       <= '0;
			out_z       <= '0;
			index_error <= 1'b1;
		end else if (tag_s1.valid && tag_s1.last) begin
			out_x       <= $signed(sum_x << tag_s1.shift);
			out_y       <= $signed(sum_y << tag_s1.shift);
			out_z       <= $signed(sum_z << tag_s1.shift);
			index_error <= 1'b0;
		end
	end

endmodule
